// File: design/baef_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// baef_pkg
// Shared types, register indexes and the fixed-point exponential used to
// build the weight tables of the bilateral alpha edge filter.
// ============================================================================
package baef_pkg;

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_PRESENT = 2'd2;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

    localparam int              RANGE_ENTRIES = 256;
    localparam longint unsigned RANGE_DEN     = 64'd800;

    typedef logic [31:0] t_pix;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic             alpha_present;
    } t_cfg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       filt;
        logic       last;
    } t_job;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_res;

    typedef enum logic [2:0] {
        F_IDLE,
        F_ADJ,
        F_RD,
        F_WIN,
        F_CTR
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MAC,
        B_CLAMP,
        B_DIV,
        B_OUT
    } t_back_state;

    // Returns round(65536 * exp(-x)) where y is x/1024 in Q32.
    function automatic logic [15:0] f_exp_q16(input longint unsigned y);
        longint unsigned y2;
        longint unsigned y3;
        longint unsigned e;
        longint unsigned r;
        logic [15:0]     res;
        if (y == 64'd0) begin
            res = 16'hFFFF;
        end else if (y >= 64'h8000_0000) begin
            res = 16'h0000;
        end else begin
            y2 = (y * y) >> 32;
            y3 = (y2 * y) >> 32;
            e  = 64'h1_0000_0000 - y + y2 / 2 - y3 / 6;
            for (int k = 0; k < 10; k++) begin
                e = (e * e + 64'h8000_0000) >> 32;
            end
            r   = (e + 64'd32768) >> 16;
            res = (r > 64'd65535) ? 16'hFFFF : r[15:0];
        end
        return res;
    endfunction

endpackage

// File: design/baef_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// baef_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
module baef_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/baef_front.sv
`timescale 1ns / 1ps
// ============================================================================
// baef_front
// Accepts pixels, keeps the line stores and the sliding window, tracks the
// raster position and issues one job per output pixel.
// ============================================================================
module baef_front #(
    parameter int HALF_WINDOW = 4,
    parameter int MAX_WIDTH   = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  baef_pkg::t_cfg    i_cfg,
    input  logic              i_push,
    output logic              o_full,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    input  logic [7:0]        i_alpha,
    input  logic              i_frame_start,
    input  logic              i_padding,
    output logic              o_job_push,
    output baef_pkg::t_job    o_job,
    input  logic              i_job_full,
    input  logic              i_take,
    output baef_pkg::t_pix    o_win [(2*HALF_WINDOW+1)*(2*HALF_WINDOW+1)]
);

    localparam int WIN    = 2 * HALF_WINDOW + 1;
    localparam int SLOTS  = 2 * HALF_WINDOW;
    localparam int NSAMP  = WIN * WIN;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ITEM_W = COL_W + baef_pkg::CFG_W + 1;
    localparam int SLOT_W = $clog2(SLOTS);

    baef_pkg::t_front_state r_state, n_state;

    logic [COL_W-1:0]  r_col, n_col, r_ocol, n_ocol;
    logic [ITEM_W-1:0] r_item, n_item, r_orow, n_orow;
    logic [SLOT_W-1:0] r_wslot, n_wslot, r_oslot, n_oslot;
    logic              r_pend, n_pend;
    logic [ITEM_W-1:0] r_limit, r_lag, r_lastidx;
    baef_pkg::t_pix    r_pix;
    logic              r_fs;
    baef_pkg::t_pix    r_win [NSAMP];

    logic [COL_W-1:0]  w_eff;
    logic [baef_pkg::CFG_W-1:0] h_eff;
    logic [ITEM_W-1:0] w_ext, total, lag;
    baef_pkg::t_pix    ram_rd  [SLOTS];
    baef_pkg::t_pix    win_col [SLOTS];
    baef_pkg::t_pix    centre;
    logic              win_shift, centre_rd, wr_en, need_out, interior;
    logic [COL_W-1:0]  col0, ocol0;

    always_comb begin
        if (i_cfg.width == '0) begin
            w_eff = COL_W'(1);
        end else if (32'(i_cfg.width) > MAX_WIDTH) begin
            w_eff = COL_W'(MAX_WIDTH);
        end else begin
            w_eff = COL_W'(i_cfg.width);
        end
        h_eff = (i_cfg.height == '0) ? baef_pkg::CFG_W'(1) : i_cfg.height;
    end

    assign w_ext = ITEM_W'(w_eff);
    assign total = w_ext * ITEM_W'(h_eff);
    assign lag   = w_ext * ITEM_W'(HALF_WINDOW) + ITEM_W'(HALF_WINDOW);

    always_ff @(posedge i_clk) begin
        r_limit   <= total + lag;
        r_lag     <= lag;
        r_lastidx <= total + lag - ITEM_W'(1);
    end

    always_comb begin
        logic [SLOT_W:0] sel;
        for (int i = 0; i < SLOTS; i++) begin
            sel = (SLOT_W + 1)'(r_wslot) + (SLOT_W + 1)'(i);
            if (sel >= (SLOT_W + 1)'(SLOTS)) begin
                sel = sel - (SLOT_W + 1)'(SLOTS);
            end
            win_col[i] = ram_rd[sel[SLOT_W-1:0]];
        end
    end

    assign centre   = ram_rd[r_oslot];
    assign need_out = (r_item >= r_lag);
    assign interior = (r_ocol >= COL_W'(HALF_WINDOW))
                   && ((COL_W + 1)'(r_ocol) + (COL_W + 1)'(HALF_WINDOW)
                       < (COL_W + 1)'(w_eff))
                   && (r_orow >= ITEM_W'(HALF_WINDOW))
                   && (r_orow + ITEM_W'(HALF_WINDOW) < ITEM_W'(h_eff));

    always_comb begin
        o_job.red   = centre[7:0];
        o_job.green = centre[15:8];
        o_job.blue  = centre[23:16];
        o_job.alpha = centre[31:24];
        o_job.filt  = i_cfg.alpha_present && (centre[31:24] != 8'd0) && interior;
        o_job.last  = (r_item == r_lastidx);
    end

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_ocol     = r_ocol;
        n_item     = r_item;
        n_orow     = r_orow;
        n_wslot    = r_wslot;
        n_oslot    = r_oslot;
        n_pend     = r_pend && !i_take;
        o_full     = 1'b1;
        o_job_push = 1'b0;
        win_shift  = 1'b0;
        centre_rd  = 1'b0;
        wr_en      = 1'b0;
        col0       = r_fs ? '0 : r_col;
        ocol0      = r_fs ? '0 : r_ocol;
        unique case (r_state)
            baef_pkg::F_IDLE: begin
                o_full = 1'b0;
                if (i_push) begin
                    n_state = baef_pkg::F_ADJ;
                end
            end
            baef_pkg::F_ADJ: begin
                n_col   = (col0 >= w_eff) ? '0 : col0;
                n_ocol  = (ocol0 >= w_eff) ? '0 : ocol0;
                n_item  = r_fs ? '0 : r_item;
                n_orow  = r_fs ? '0 : r_orow;
                n_wslot = r_fs ? '0 : r_wslot;
                n_oslot = r_fs ? '0 : r_oslot;
                n_state = (n_item >= r_limit) ? baef_pkg::F_IDLE : baef_pkg::F_RD;
            end
            baef_pkg::F_RD: begin
                n_state = baef_pkg::F_WIN;
            end
            baef_pkg::F_WIN: begin
                if (!r_pend) begin
                    win_shift = 1'b1;
                    centre_rd = 1'b1;
                    n_state   = baef_pkg::F_CTR;
                end
            end
            baef_pkg::F_CTR: begin
                centre_rd = 1'b1;
                if (!(need_out && i_job_full)) begin
                    o_job_push = need_out;
                    wr_en      = 1'b1;
                    n_item     = r_item + ITEM_W'(1);
                    if (need_out && o_job.filt) begin
                        n_pend = 1'b1;
                    end
                    if (need_out) begin
                        if ((COL_W + 1)'(r_ocol) + (COL_W + 1)'(1) >= (COL_W + 1)'(w_eff))
                        begin
                            n_ocol  = '0;
                            n_orow  = r_orow + ITEM_W'(1);
                            n_oslot = (r_oslot == SLOT_W'(SLOTS - 1)) ? '0
                                    : r_oslot + SLOT_W'(1);
                        end else begin
                            n_ocol = r_ocol + COL_W'(1);
                        end
                    end
                    if ((COL_W + 1)'(r_col) + (COL_W + 1)'(1) >= (COL_W + 1)'(w_eff)) begin
                        n_col   = '0;
                        n_wslot = (r_wslot == SLOT_W'(SLOTS - 1)) ? '0
                                : r_wslot + SLOT_W'(1);
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                    n_state = baef_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = baef_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= baef_pkg::F_IDLE;
            r_col   <= '0;
            r_ocol  <= '0;
            r_item  <= '0;
            r_orow  <= '0;
            r_wslot <= '0;
            r_oslot <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_ocol  <= n_ocol;
            r_item  <= n_item;
            r_orow  <= n_orow;
            r_wslot <= n_wslot;
            r_oslot <= n_oslot;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == baef_pkg::F_IDLE && i_push) begin
            r_pix <= i_padding ? '0 : {i_alpha, i_blue, i_green, i_red};
            r_fs  <= i_frame_start;
        end
    end

    for (genvar n = 0; n < NSAMP; n++) begin : g_win
        if ((n % WIN) != (WIN - 1)) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (win_shift) begin
                    r_win[n] <= r_win[n+1];
                end
            end
        end else if ((n / WIN) < SLOTS) begin : g_store
            always_ff @(posedge i_clk) begin
                if (win_shift) begin
                    r_win[n] <= win_col[n/WIN];
                end
            end
        end else begin : g_new
            always_ff @(posedge i_clk) begin
                if (win_shift) begin
                    r_win[n] <= r_pix;
                end
            end
        end
        assign o_win[n] = r_win[n];
    end

    for (genvar k = 0; k < SLOTS; k++) begin : g_line
        logic [ADDR_W-1:0] raddr;
        assign raddr = (centre_rd && (r_oslot == SLOT_W'(k))) ? r_ocol[ADDR_W-1:0]
                     : r_col[ADDR_W-1:0];
        baef_ram #(
            .WIDTH (32),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (wr_en && (r_wslot == SLOT_W'(k))),
            .i_waddr (r_col[ADDR_W-1:0]),
            .i_wdata (r_pix),
            .i_raddr (raddr),
            .o_rdata (ram_rd[k])
        );
    end

    a_pend_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == baef_pkg::F_WIN && r_pend) |=> (r_state == baef_pkg::F_WIN))
        else $error("window shifted while a filter job was still waiting");

endmodule

// File: design/baef_job_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// baef_job_fifo
// Two-entry queue of pixel jobs between the front end and the filter core.
// ============================================================================
module baef_job_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  baef_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output baef_pkg::t_job o_job,
    output logic           o_empty
);

    baef_pkg::t_job r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// File: design/baef_back.sv
`timescale 1ns / 1ps
// ============================================================================
// baef_back
// Filter core: one shared multiply-accumulate over the window samples, an
// iterative divider for the weighted mean, and the result register.
// ============================================================================
module baef_back #(
    parameter int HALF_WINDOW       = 4,
    parameter int RANGE_TABLE_SHIFT = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  baef_pkg::t_job i_job,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_take,
    input  baef_pkg::t_pix i_win [(2*HALF_WINDOW+1)*(2*HALF_WINDOW+1)],
    input  logic           i_out_pop,
    output baef_pkg::t_res o_res,
    output logic           o_valid
);

    localparam int WIN    = 2 * HALF_WINDOW + 1;
    localparam int NSAMP  = WIN * WIN;
    localparam int CNT_W  = $clog2(NSAMP + 1);
    localparam int WSUM_W = 16 + $clog2(NSAMP + 1);
    localparam int ASUM_W = WSUM_W + 8;
    localparam longint unsigned SpDen = 64'(200 * HALF_WINDOW * HALF_WINDOW);

    function automatic logic [NSAMP*16-1:0] f_sp_tab();
        logic [15:0]        s [HALF_WINDOW+1];
        logic [NSAMP*16-1:0] t;
        longint unsigned    y;
        longint unsigned    v;
        int                 di;
        int                 dj;
        t = '0;
        for (int k = 0; k <= HALF_WINDOW; k++) begin
            y    = (64'(289 * k * k) << 22) / SpDen;
            s[k] = baef_pkg::f_exp_q16(y);
        end
        for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN; j++) begin
                di = (i > HALF_WINDOW) ? i - HALF_WINDOW : HALF_WINDOW - i;
                dj = (j > HALF_WINDOW) ? j - HALF_WINDOW : HALF_WINDOW - j;
                v  = (64'(s[di]) * 64'(s[dj]) + 64'd32768) >> 16;
                t[(i*WIN+j)*16 +: 16] = v[15:0];
            end
        end
        return t;
    endfunction

    function automatic logic [baef_pkg::RANGE_ENTRIES*16-1:0] f_range_tab();
        logic [baef_pkg::RANGE_ENTRIES*16-1:0] t;
        longint unsigned y;
        t = '0;
        for (int i = 0; i < baef_pkg::RANGE_ENTRIES; i++) begin
            y = (64'(i) << (RANGE_TABLE_SHIFT + 22)) / baef_pkg::RANGE_DEN;
            t[i*16 +: 16] = baef_pkg::f_exp_q16(y);
        end
        return t;
    endfunction

    localparam logic [NSAMP*16-1:0] SpTab = f_sp_tab();
    localparam logic [baef_pkg::RANGE_ENTRIES*16-1:0] RangeTab = f_range_tab();

    baef_pkg::t_back_state r_state, n_state;

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_v1, r_v2, r_v3;
    logic [2:0]        r_bit, n_bit;
    logic [ASUM_W-1:0] r_rem, n_rem;
    logic [7:0]        r_q, n_q;
    logic              r_valid;
    baef_pkg::t_res    r_res;
    baef_pkg::t_job    r_job;
    baef_pkg::t_pix    r_snap [NSAMP];

    logic [17:0]       r_d2;
    logic [7:0]        r_a1, r_a2, r_a3;
    logic [15:0]       r_sp1;
    logic [31:0]       r_prod;
    logic [15:0]       r_wt;
    logic [WSUM_W-1:0] r_wsum;
    logic [ASUM_W-1:0] r_asum;

    logic              issue, start, load_out;
    logic [7:0]        adr, adg, adb;
    logic [17:0]       d2, idx;
    logic [15:0]       rw;
    logic [23:0]       wa;
    logic [ASUM_W-1:0] dsh, clamp_lim;

    always_comb begin
        adr = (r_snap[0][7:0] > r_job.red) ? r_snap[0][7:0] - r_job.red
            : r_job.red - r_snap[0][7:0];
        adg = (r_snap[0][15:8] > r_job.green) ? r_snap[0][15:8] - r_job.green
            : r_job.green - r_snap[0][15:8];
        adb = (r_snap[0][23:16] > r_job.blue) ? r_snap[0][23:16] - r_job.blue
            : r_job.blue - r_snap[0][23:16];
        d2  = 18'(adr) * 18'(adr) + 18'(adg) * 18'(adg) + 18'(adb) * 18'(adb);
        idx = r_d2 >> RANGE_TABLE_SHIFT;
        rw  = (idx < 18'(baef_pkg::RANGE_ENTRIES)) ? RangeTab[idx[7:0]*16 +: 16] : 16'd0;
        wa  = r_wt * r_a3;
    end

    assign dsh       = ASUM_W'(r_wsum) << r_bit;
    assign clamp_lim = ASUM_W'(r_wsum) << 8;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_bit    = r_bit;
        n_rem    = r_rem;
        n_q      = r_q;
        o_pop    = 1'b0;
        start    = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            baef_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    start   = i_job.filt;
                    n_q     = i_job.alpha;
                    n_cnt   = '0;
                    n_state = i_job.filt ? baef_pkg::B_MAC : baef_pkg::B_OUT;
                end
            end
            baef_pkg::B_MAC: begin
                if (r_cnt != CNT_W'(NSAMP)) begin
                    issue = 1'b1;
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (!r_v1 && !r_v2 && !r_v3) begin
                    n_state = baef_pkg::B_CLAMP;
                end
            end
            baef_pkg::B_CLAMP: begin
                if (r_wsum == '0) begin
                    n_state = baef_pkg::B_OUT;
                end else if (r_asum >= clamp_lim) begin
                    n_q     = 8'hFF;
                    n_state = baef_pkg::B_OUT;
                end else begin
                    n_rem   = r_asum;
                    n_q     = 8'd0;
                    n_bit   = 3'd7;
                    n_state = baef_pkg::B_DIV;
                end
            end
            baef_pkg::B_DIV: begin
                if (r_rem >= dsh) begin
                    n_rem = r_rem - dsh;
                    n_q   = r_q | (8'd1 << r_bit);
                end
                if (r_bit == 3'd0) begin
                    n_state = baef_pkg::B_OUT;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            baef_pkg::B_OUT: begin
                if (!r_valid || i_out_pop) begin
                    load_out = 1'b1;
                    n_state  = baef_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = baef_pkg::B_IDLE;
            end
        endcase
    end

    assign o_take  = start;
    assign o_res   = r_res;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= baef_pkg::B_IDLE;
            r_cnt   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_valid <= load_out || (r_valid && !i_out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
        r_rem <= n_rem;
        r_q   <= n_q;
        if (o_pop) begin
            r_job <= i_job;
        end
        if (issue) begin
            r_d2  <= d2;
            r_a1  <= r_snap[0][31:24];
            r_sp1 <= SpTab[r_cnt*16 +: 16];
        end
        r_prod <= r_sp1 * rw;
        r_a2   <= r_a1;
        r_wt   <= r_prod[31:16];
        r_a3   <= r_a2;
        if (start) begin
            r_wsum <= '0;
            r_asum <= '0;
        end else if (r_v3) begin
            r_wsum <= r_wsum + WSUM_W'(r_wt);
            r_asum <= r_asum + ASUM_W'(wa);
        end
        if (load_out) begin
            r_res.red   <= r_job.red;
            r_res.green <= r_job.green;
            r_res.blue  <= r_job.blue;
            r_res.alpha <= r_q;
            r_res.last  <= r_job.last;
        end
    end

    for (genvar n = 0; n < NSAMP; n++) begin : g_snap
        always_ff @(posedge i_clk) begin
            if (start) begin
                r_snap[n] <= i_win[n];
            end else if (issue) begin
                r_snap[n] <= r_snap[(n + 1) % NSAMP];
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(NSAMP))
        else $error("sample counter ran past the window");

    a_mac_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2 || r_v3) |-> (r_state == baef_pkg::B_MAC))
        else $error("accumulator pipeline busy outside the accumulate phase");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == baef_pkg::B_DIV) |->
            (r_rem < (ASUM_W'(r_wsum) << ({1'b0, r_bit} + 4'd1))))
        else $error("divider remainder out of bounds");

endmodule

// File: design/bilateral_alpha_edge_filter_top.sv
`timescale 1ns / 1ps
// ============================================================================
// bilateral_alpha_edge_filter_top
// Joint bilateral filter on the alpha channel of a raster RGBA stream.
// ============================================================================
// Pixels enter through a queue-style port: a transaction completes when push
// is high and full is low. Results leave the same way: the oldest result sits
// on the output ports while empty is low and completes when pop is high.
// Frame width, height and the alpha-enable flag are written through a plain
// register port; write them only while the block has no work in flight.
// Output lags input by HALF_WINDOW rows plus HALF_WINDOW pixels, and padding
// transactions push out the final pixels of a frame.
// For each pixel the front end adjusts its raster position, reads the line
// stores, shifts the window and writes back. A filtered pixel passes the
// filter core's shared multiply-accumulate one sample per cycle, then an
// eight-step divide unless the mean clamps to 255 or the weights sum to 0.
// Border, zero-alpha and unfiltered pixels skip to the result register.
// A two-entry job queue and one result register let either side stall alone;
// while pop is held low the block keeps accepting until its queues fill.
// Synchronous reset clears the counters and queues and restores the default
// configuration; the line stores are not cleared and need no clearing pass.
// ============================================================================
module bilateral_alpha_edge_filter_top #(
    parameter int HALF_WINDOW       = 4,
    parameter int MAX_WIDTH         = 2048,
    parameter int RANGE_TABLE_SHIFT = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_red_in,
    input  logic [7:0]                     i_green_in,
    input  logic [7:0]                     i_blue_in,
    input  logic [7:0]                     i_alpha_in,
    input  logic                           i_frame_start,
    input  logic                           i_padding,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_red_out,
    output logic [7:0]                     o_green_out,
    output logic [7:0]                     o_blue_out,
    output logic [7:0]                     o_alpha_out,
    output logic                           o_frame_last,
    input  logic                           i_cfg_we,
    input  logic [baef_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [baef_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int WIN   = 2 * HALF_WINDOW + 1;
    localparam int NSAMP = WIN * WIN;

    baef_pkg::t_cfg r_cfg;
    baef_pkg::t_job front_job, fifo_job;
    baef_pkg::t_res res;
    baef_pkg::t_pix win [NSAMP];
    logic           job_push, job_full, job_pop, job_empty, take, res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width         <= baef_pkg::RESET_WIDTH;
            r_cfg.height        <= baef_pkg::RESET_HEIGHT;
            r_cfg.alpha_present <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                baef_pkg::CFG_FRAME_WIDTH:   r_cfg.width         <= i_cfg_data;
                baef_pkg::CFG_FRAME_HEIGHT:  r_cfg.height        <= i_cfg_data;
                baef_pkg::CFG_ALPHA_PRESENT: r_cfg.alpha_present <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    baef_front #(
        .HALF_WINDOW (HALF_WINDOW),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (push),
        .o_full        (full),
        .i_red         (i_red_in),
        .i_green       (i_green_in),
        .i_blue        (i_blue_in),
        .i_alpha       (i_alpha_in),
        .i_frame_start (i_frame_start),
        .i_padding     (i_padding),
        .o_job_push    (job_push),
        .o_job         (front_job),
        .i_job_full    (job_full),
        .i_take        (take),
        .o_win         (win)
    );

    baef_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_job   (fifo_job),
        .o_empty (job_empty)
    );

    baef_back #(
        .HALF_WINDOW       (HALF_WINDOW),
        .RANGE_TABLE_SHIFT (RANGE_TABLE_SHIFT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (fifo_job),
        .i_empty   (job_empty),
        .o_pop     (job_pop),
        .o_take    (take),
        .i_win     (win),
        .i_out_pop (pop),
        .o_res     (res),
        .o_valid   (res_valid)
    );

    assign empty        = !res_valid;
    assign o_red_out    = res.red;
    assign o_green_out  = res.green;
    assign o_blue_out   = res.blue;
    assign o_alpha_out  = res.alpha;
    assign o_frame_last = res.last;

endmodule

// File: tb/sv/tb_bilateral_alpha_edge_filter_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_bilateral_alpha_edge_filter_top
// Self-checking testbench for the bilateral alpha edge filter.
// ============================================================================
// Small RGBA frames are streamed through the queue-style input, with frame
// sizes, alpha enable and padding flushes varied between frames. A built-in
// predictor keeps its own line store, window and weight tables and computes
// each expected output pixel, which is compared field by field with what
// leaves the block. Both sides idle at random, and once the output side holds
// off long enough for the block to stall its input.
// ============================================================================
module tb_bilateral_alpha_edge_filter_top;

    localparam int HW     = 4;
    localparam int WIN    = 2 * HW + 1;
    localparam int SLOTS  = 2 * HW;
    localparam int MAX_W  = 2048;
    localparam int RSHIFT = 6;
    localparam int SETTLE = 200;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       fstart;
        logic       pad;
    } t_pixel_in;

    localparam int N_DIRECTED = 16;
    localparam t_pixel_in DIRECTED [N_DIRECTED] = '{
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b0},
        '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0},
        '{8'd255, 8'd0,   8'd0,   8'd128, 1'b0, 1'b0},
        '{8'd0,   8'd255, 8'd0,   8'd1,   1'b0, 1'b0},
        '{8'd0,   8'd0,   8'd255, 8'd254, 1'b0, 1'b0},
        '{8'd170, 8'd85,  8'd170, 8'd85,  1'b0, 1'b0},
        '{8'd85,  8'd170, 8'd85,  8'd170, 1'b0, 1'b0},
        '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1},
        '{8'd128, 8'd128, 8'd128, 8'd0,   1'b0, 1'b0},
        '{8'd128, 8'd128, 8'd128, 8'd255, 1'b0, 1'b0},
        '{8'd130, 8'd126, 8'd128, 8'd200, 1'b0, 1'b0},
        '{8'd128, 8'd128, 8'd128, 8'd255, 1'b0, 1'b0},
        '{8'd120, 8'd136, 8'd128, 8'd10,  1'b0, 1'b0},
        '{8'd128, 8'd128, 8'd128, 8'd255, 1'b0, 1'b0},
        '{8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 1'b0},
        '{8'd128, 8'd128, 8'd128, 8'd255, 1'b0, 1'b0}
    };

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           push          = 1'b0;
    logic                           full;
    logic [7:0]                     i_red_in      = '0;
    logic [7:0]                     i_green_in    = '0;
    logic [7:0]                     i_blue_in     = '0;
    logic [7:0]                     i_alpha_in    = '0;
    logic                           i_frame_start = 1'b0;
    logic                           i_padding     = 1'b0;
    logic                           empty;
    logic                           pop           = 1'b0;
    logic [7:0]                     o_red_out;
    logic [7:0]                     o_green_out;
    logic [7:0]                     o_blue_out;
    logic [7:0]                     o_alpha_out;
    logic                           o_frame_last;
    logic                           i_cfg_we      = 1'b0;
    logic [baef_pkg::CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [baef_pkg::CFG_W-1:0]     i_cfg_data    = '0;

    bilateral_alpha_edge_filter_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_alpha_in    (i_alpha_in),
        .i_frame_start (i_frame_start),
        .i_padding     (i_padding),
        .empty         (empty),
        .pop           (pop),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .o_alpha_out   (o_alpha_out),
        .o_frame_last  (o_frame_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Predictor state.
    logic [31:0]  line_mem [SLOTS*MAX_W];
    logic [31:0]  win_regs [WIN][WIN];
    logic [15:0]  spatial_wt [WIN][WIN];
    logic [15:0]  range_wt [256];
    int unsigned  col_cnt, row_cnt, pix_cnt, out_col, out_row;
    logic [11:0]  cfg_width, cfg_height;
    logic         cfg_alpha;

    baef_pkg::t_res pending_pixels [$];
    int           err_count  = 0;
    bit           hold_req   = 1'b0;
    bit           no_idle    = 1'b0;
    bit           noisy      = 1'b0;
    logic [7:0]   base_r, base_g, base_b;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [15:0] neg_exp_q16(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned y, y2, y3, e, r;
        if (num == 0 || den == 0) return 16'hFFFF;
        y = (num << 22) / den;
        if (y == 0) return 16'hFFFF;
        if (y >= 64'h8000_0000) return 16'h0000;
        y2 = (y * y) >> 32;
        y3 = (y2 * y) >> 32;
        e  = 64'h1_0000_0000 - y + y2 / 2 - y3 / 6;
        for (int k = 0; k < 10; k++) e = (e * e + 64'h8000_0000) >> 32;
        r = (e + 64'd32768) >> 16;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic void build_weights();
        logic [15:0]     s1 [HW+1];
        longint unsigned prod;
        int              di, dj;
        for (int k = 0; k <= HW; k++) begin
            s1[k] = neg_exp_q16(64'(289 * k * k), 64'(200 * HW * HW));
        end
        for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN; j++) begin
                di = (i > HW) ? i - HW : HW - i;
                dj = (j > HW) ? j - HW : HW - j;
                prod = longint'(s1[di]) * s1[dj] + 32768;
                spatial_wt[i][j] = prod[31:16];
            end
        end
        for (int i = 0; i < 256; i++) begin
            range_wt[i] = neg_exp_q16(longint'(i) << RSHIFT, 64'd800);
        end
    endfunction

    function automatic void filter_step(input t_pixel_in it);
        int unsigned     w, h, total, lag, px, ctr, alf, d2, idx;
        int              dr, dg, db;
        longint unsigned acc_a, acc_w, wt, q;
        baef_pkg::t_res  res;
        w = cfg_width;
        h = cfg_height;
        if (w == 0) w = 1;
        if (w > MAX_W) w = MAX_W;
        if (h == 0) h = 1;
        total = w * h;
        lag   = HW * w + HW;
        if (it.fstart) begin
            col_cnt = 0; row_cnt = 0; pix_cnt = 0; out_col = 0; out_row = 0;
        end
        if (col_cnt >= w) col_cnt = 0;
        if (out_col >= w) out_col = 0;
        if (pix_cnt >= total + lag) return;
        px = it.pad ? 0 : {it.alpha, it.blue, it.green, it.red};
        for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN - 1; j++) win_regs[i][j] = win_regs[i][j+1];
        end
        for (int i = 0; i < SLOTS; i++) begin
            win_regs[i][WIN-1] = line_mem[((row_cnt + i) % SLOTS) * MAX_W + col_cnt];
        end
        win_regs[SLOTS][WIN-1] = px;
        if (pix_cnt >= lag) begin
            ctr = line_mem[(out_row % SLOTS) * MAX_W + out_col];
            alf = 32'(ctr[31:24]);
            if (cfg_alpha && alf != 0 && out_col >= HW && out_col + HW < w &&
                out_row >= HW && out_row + HW < h) begin
                acc_a = 0;
                acc_w = 0;
                for (int i = 0; i < WIN; i++) begin
                    for (int j = 0; j < WIN; j++) begin
                        dr  = int'(win_regs[i][j][7:0]) - int'(ctr[7:0]);
                        dg  = int'(win_regs[i][j][15:8]) - int'(ctr[15:8]);
                        db  = int'(win_regs[i][j][23:16]) - int'(ctr[23:16]);
                        d2  = dr * dr + dg * dg + db * db;
                        idx = d2 >> RSHIFT;
                        wt  = (idx < 256) ? 64'(range_wt[idx]) : 64'd0;
                        wt  = (wt * spatial_wt[i][j]) >> 16;
                        acc_a += wt * win_regs[i][j][31:24];
                        acc_w += wt;
                    end
                end
                if (acc_w != 0) begin
                    q   = acc_a / acc_w;
                    alf = (q > 255) ? 32'd255 : 32'(q);
                end
            end
            res.red   = ctr[7:0];
            res.green = ctr[15:8];
            res.blue  = ctr[23:16];
            res.alpha = alf[7:0];
            res.last  = (pix_cnt - lag == total - 1);
            pending_pixels.push_back(res);
            if (out_col + 1 >= w) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col++;
            end
        end
        line_mem[(row_cnt % SLOTS) * MAX_W + col_cnt] = px;
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            row_cnt++;
        end else begin
            col_cnt++;
        end
        pix_cnt++;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] near(input logic [7:0] base);
        int v;
        v = int'(base) + $urandom_range(0, 24) - 12;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic t_pixel_in random_pixel();
        t_pixel_in p;
        int        r;
        if ($urandom_range(0, 99) < 80) begin
            p.red   = near(base_r);
            p.green = near(base_g);
            p.blue  = near(base_b);
        end else begin
            p.red   = 8'($urandom_range(0, 255));
            p.green = 8'($urandom_range(0, 255));
            p.blue  = 8'($urandom_range(0, 255));
        end
        r = $urandom_range(0, 99);
        p.alpha  = (r < 30) ? 8'd255 : (r < 45) ? 8'd0 : 8'($urandom_range(0, 255));
        p.fstart = 1'b0;
        p.pad    = 1'b0;
        return p;
    endfunction

    task automatic wait_idle();
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [baef_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[baef_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            baef_pkg::CFG_FRAME_WIDTH:   cfg_width  = val[11:0];
            baef_pkg::CFG_FRAME_HEIGHT:  cfg_height = val[11:0];
            baef_pkg::CFG_ALPHA_PRESENT: cfg_alpha  = val[0];
            default: ;
        endcase
    endtask

    // Streams one frame: pixels, then padding to flush, then extra items
    // that arrive after the frame has ended and are ignored.
    task automatic play_frame(input int unsigned wv, input int unsigned hv,
                              input bit ap, input int unsigned n_items,
                              input bit use_table);
        int unsigned we, he, total, gap;
        t_pixel_in   it;
        wait_idle();
        write_reg(baef_pkg::CFG_FRAME_WIDTH, wv);
        write_reg(baef_pkg::CFG_FRAME_HEIGHT, hv);
        write_reg(baef_pkg::CFG_ALPHA_PRESENT, ap);
        we = (wv == 0) ? 1 : (wv > MAX_W) ? MAX_W : wv;
        he = (hv == 0) ? 1 : hv;
        total  = we * he;
        base_r = 8'($urandom_range(0, 255));
        base_g = 8'($urandom_range(0, 255));
        base_b = 8'($urandom_range(0, 255));
        for (int unsigned k = 0; k < n_items; k++) begin
            if (use_table && k < N_DIRECTED) begin
                it = DIRECTED[k];
            end else begin
                it = random_pixel();
                if (k >= total) it.pad = 1'b1;
                if (noisy && $urandom_range(0, 99) < 3) it.pad = 1'b1;
                if (noisy && $urandom_range(0, 199) == 0) it.fstart = 1'b1;
                if ($urandom_range(0, 99) < 10) it.pad = ~it.pad & (k >= total);
            end
            if (k == 0) it.fstart = 1'b1;
            push          <= 1'b1;
            i_red_in      <= it.red;
            i_green_in    <= it.green;
            i_blue_in     <= it.blue;
            i_alpha_in    <= it.alpha;
            i_frame_start <= it.fstart;
            i_padding     <= it.pad;
            do @(posedge i_clk); while (full);
            filter_step(it);
            gap = idle_len();
            if (gap != 0 || k == n_items - 1) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        int             stall_left;
        baef_pkg::t_res got, want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got = '{o_red_out, o_green_out, o_blue_out, o_alpha_out, o_frame_last};
                if (pending_pixels.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) $display("Unexpected output pixel %p", got);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("Output pixel mismatch: expected %p, got %p", want, got);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = 2000;
                pop <= 1'b0;
            end else begin
                stall_left = idle_len();
                pop <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    initial begin
        int unsigned wv, hv;
        for (int i = 0; i < SLOTS * MAX_W; i++) line_mem[i] = '0;
        for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN; j++) win_regs[i][j] = '0;
        end
        build_weights();
        col_cnt = 0; row_cnt = 0; pix_cnt = 0; out_col = 0; out_row = 0;
        cfg_width  = baef_pkg::RESET_WIDTH;
        cfg_height = baef_pkg::RESET_HEIGHT;
        cfg_alpha  = 1'b1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Nine-by-nine frame, led by the directed pixels, with trailing extras.
        play_frame(9, 9, 1'b1, 81 + 40 + 4, 1'b1);
        for (int f = 0; f < 3; f++) begin
            wv = $urandom_range(9, 12);
            hv = $urandom_range(9, 10);
            noisy   = (f == 2);
            no_idle = (f == 0);
            if (f == 1) hold_req = 1'b1;
            play_frame(wv, hv, 1'b1, wv * hv + HW * wv + HW + $urandom_range(0, 3), 1'b0);
        end
        noisy   = 1'b0;
        no_idle = 1'b0;
        play_frame(10, 9, 1'b0, 90 + 44, 1'b0);
        play_frame(0, 9, 1'b1, 9 + 8 + 2, 1'b0);
        play_frame(9, 0, 1'b1, 9 + 40 + 2, 1'b0);
        play_frame(2048, 2048, 1'b1, 50, 1'b0);
        play_frame(4095, 9, 1'b1, 50, 1'b0);
        play_frame(9, 4095, 1'b1, 60, 1'b0);
        play_frame(12, 10, 1'b1, 120 + 52, 1'b0);

        wait_idle();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
